### sv/mts_pkg.sv
// ----------------------------------------------------------------------------
// Max-tracking stack package
// Field widths, command and status codes, and the per-cell entry type shared
// by the stack cells and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mts_pkg;

  localparam int VALUE_W       = 30;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int FILL_W        = 11;
  localparam int DEPTH_DEFAULT = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stack slot: the stored value and the maximum of it and every slot
  // beneath it.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] run_max;
  } entry_t;

  // Shift control broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

### sv/mts_cell.sv
// ----------------------------------------------------------------------------
// Max-tracking stack cell
// One slot of the shifting stack. A push moves the slot above into this one,
// a pop moves the slot below up into this one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_cell (
  input  logic            clk,
  input  mts_pkg::shift_t shift,
  input  mts_pkg::entry_t from_above,
  input  mts_pkg::entry_t from_below,
  output mts_pkg::entry_t entry
);
  import mts_pkg::*;

  always_ff @(posedge clk) begin
    if (shift.push) begin
      entry <= from_above;
    end else if (shift.pop) begin
      entry <= from_below;
    end
  end

endmodule

### sv/max_tracking_stack.sv
// ----------------------------------------------------------------------------
// Max-tracking stack
// done is registered: the result of an item appears with done in the cycle after start.
// Throughput: one item per cycle; busy stays low, since every command only
// shifts the cell chain by at most one slot and reads the top cell.
// Reset: synchronous rst empties the stack (count and done cleared); cell
// contents are left as they are and are never read until pushed again.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_tracking_stack #(
  parameter int DEPTH = mts_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [mts_pkg::CMD_W-1:0]    command,
  input  logic [mts_pkg::VALUE_W-1:0]  value,
  output logic                         done,
  output logic [mts_pkg::VALUE_W-1:0]  data,
  output logic [mts_pkg::STATUS_W-1:0] status,
  output logic [mts_pkg::FILL_W-1:0]   fill_level
);
  import mts_pkg::*;

  // The count must hold DEPTH itself, so its width is taken from DEPTH + 1.
  localparam int CW = $clog2(DEPTH + 1);

  // The stack is a chain of cells with the top of stack in cell 0. A push
  // shifts every cell one place deeper and loads cell 0 with the new item;
  // a pop shifts every cell one place up. Because each cell carries the
  // running maximum of itself and everything beneath it, and shifting keeps
  // the order of the cells, the current maximum is always in cell 0.
  entry_t cells [DEPTH];
  entry_t new_entry;
  shift_t shift;

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [VALUE_W-1:0]     data_next;
  status_t                status_next;
  logic [CW+FILL_W-1:0]   fill_wide;
  cmd_t                   cmd;
  logic                   accept;
  logic                   empty;
  logic                   full;

  // Every command is finished when it is taken, so the block never holds off start.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cmd    = cmd_t'(command);
  assign empty  = (count == '0);
  assign full   = (count == CW'(DEPTH));

  // The new top entry inherits the larger of its own value and the running
  // maximum of the current top, unless the stack is empty.
  always_comb begin
    new_entry.value   = value;
    new_entry.run_max = value;
    if (!empty && (cells[0].run_max > value)) begin
      new_entry.run_max = cells[0].run_max;
    end
  end

  // Command decode. A rejected push or an operation on an empty stack leaves
  // the chain and the count untouched; the unused command code does nothing.
  always_comb begin
    shift       = '0;
    count_next  = count;
    data_next   = '0;
    status_next = ST_OK;
    if (accept) begin
      unique case (cmd)
        CMD_PUSH: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            shift.push = 1'b1;
            count_next = count + CW'(1);
          end
        end
        CMD_POP: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            shift.pop  = 1'b1;
            count_next = count - CW'(1);
            data_next  = cells[0].value;
          end
        end
        CMD_READ: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            data_next = cells[0].run_max;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The reported fill level is the count reduced to the port width.
  assign fill_wide = {{FILL_W{1'b0}}, count_next};

  // Cell chain. The deepest cell has nothing below it; what it takes on a
  // pop lies past the count and is never read.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t above;
    entry_t below;
    if (i == 0) begin : g_top
      assign above = new_entry;
    end else begin : g_mid
      assign above = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_bottom
      assign below = cells[i];
    end else begin : g_inner
      assign below = cells[i+1];
    end
    mts_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_above (above),
      .from_below (below),
      .entry      (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Result registers carry payload only and need no reset.
  always_ff @(posedge clk) begin
    data       <= data_next;
    status     <= status_next;
    fill_level <= fill_wide[FILL_W-1:0];
  end

  // Every accepted item yields exactly one result in the following cycle.
  assert property (@(posedge clk) disable iff (rst) accept |=> done)
    else $error("accepted item produced no result");
  assert property (@(posedge clk) disable iff (rst) !accept |=> !done)
    else $error("result without an accepted item");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("stack count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL) |-> full)
    else $error("full status while stack not full");
  assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_EMPTY) |-> empty && (data == '0))
    else $error("empty status with data or entries");
  assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_PUSH) && !full |=> count == $past(count) + CW'(1))
    else $error("push did not grow the stack");

endmodule

### tb/tb_max_tracking_stack.sv
// ----------------------------------------------------------------------------
// Max-tracking stack testbench
// Drives push, pop, read-max and unused command items through the start/busy
// handshake with random gaps. A shadow stack in the bench predicts each item's
// data, status and fill level, and every done strobe is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_max_tracking_stack;
  import mts_pkg::*;

  // The block runs at its default depth, so one stretch of the random part
  // climbs all the way to full and works the boundary there.
  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1400;
  localparam int MAX_GAP      = 18;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  // Command code 3 is not defined; the block must treat it as a no-op.
  localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
  localparam logic [VALUE_W-1:0] VALUE_MAX  = '1;

  // One result of the block, in port order.
  typedef struct packed {
    logic [VALUE_W-1:0]  data;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill;
  } stack_result_t;

  // One row of the directed table. When known is set, the typed-in result is
  // the expectation; otherwise the shadow stack supplies it.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] val;
    logic               known;
    stack_result_t      res;
  } directed_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    command;
  logic [VALUE_W-1:0]  value;
  logic                done;
  logic [VALUE_W-1:0]  data;
  logic [STATUS_W-1:0] status;
  logic [FILL_W-1:0]   fill_level;

  // Shadow copy of the stack: stored values, running maxima and the count.
  logic [VALUE_W-1:0] shadow_value [DEPTH];
  logic [VALUE_W-1:0] shadow_max   [DEPTH];
  int unsigned        shadow_count;

  // Results predicted for accepted items, oldest first.
  stack_result_t pending_results [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned random_count;

  // Idle pattern state: stretches of back-to-back items alternate with
  // stretches where every item waits a random number of cycles.
  int unsigned stretch_left;
  bit          back_to_back;

  // Directed items, starting from an empty stack right after reset. The
  // empty-stack errors, the extremes of the value field and the unused
  // command code are all covered here.
  directed_row_t directed_rows [23] = '{
    '{CMD_POP,    30'h00000000, 1'b1, '{30'h00000000, ST_EMPTY, 11'd0}},
    '{CMD_READ,   30'h3FFFFFFF, 1'b1, '{30'h00000000, ST_EMPTY, 11'd0}},
    '{CMD_UNUSED, 30'h3FFFFFFF, 1'b1, '{30'h00000000, ST_OK,    11'd0}},
    '{CMD_PUSH,   30'h00000000, 1'b1, '{30'h00000000, ST_OK,    11'd1}},
    '{CMD_READ,   30'h00000000, 1'b1, '{30'h00000000, ST_OK,    11'd1}},
    '{CMD_PUSH,   30'h3FFFFFFF, 1'b1, '{30'h00000000, ST_OK,    11'd2}},
    '{CMD_READ,   30'h00000000, 1'b1, '{30'h3FFFFFFF, ST_OK,    11'd2}},
    '{CMD_PUSH,   30'h00000005, 1'b1, '{30'h00000000, ST_OK,    11'd3}},
    '{CMD_READ,   30'h00000000, 1'b1, '{30'h3FFFFFFF, ST_OK,    11'd3}},
    '{CMD_POP,    30'h00000000, 1'b1, '{30'h00000005, ST_OK,    11'd2}},
    '{CMD_POP,    30'h00000000, 1'b1, '{30'h3FFFFFFF, ST_OK,    11'd1}},
    '{CMD_READ,   30'h3FFFFFFF, 1'b1, '{30'h00000000, ST_OK,    11'd1}},
    '{CMD_PUSH,   30'h2AAAAAAA, 1'b0, '0},
    '{CMD_PUSH,   30'h15555555, 1'b0, '0},
    '{CMD_READ,   30'h15555555, 1'b0, '0},
    '{CMD_POP,    30'h3FFFFFFF, 1'b0, '0},
    '{CMD_UNUSED, 30'h00000000, 1'b0, '0},
    '{CMD_POP,    30'h00000000, 1'b0, '0},
    '{CMD_POP,    30'h00000000, 1'b1, '{30'h00000000, ST_OK,    11'd0}},
    '{CMD_POP,    30'h3FFFFFFF, 1'b1, '{30'h00000000, ST_EMPTY, 11'd0}},
    '{CMD_PUSH,   30'h00000001, 1'b0, '0},
    '{CMD_READ,   30'h3FFFFFFF, 1'b0, '0},
    '{CMD_POP,    30'h00000000, 1'b0, '0}
  };

  max_tracking_stack #(
    .DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .value      (value),
    .done       (done),
    .data       (data),
    .status     (status),
    .fill_level (fill_level)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one command to the shadow stack and returns the result the block
  // should give for it. A rejected push and every error leave the stack as
  // it was.
  function automatic stack_result_t stack_apply(input logic [CMD_W-1:0] cmd,
                                                input logic [VALUE_W-1:0] val);
    stack_result_t      r;
    logic [VALUE_W-1:0] run_max;
    r        = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          run_max = val;
          if (shadow_count > 0 && shadow_max[shadow_count - 1] > run_max) begin
            run_max = shadow_max[shadow_count - 1];
          end
          shadow_value[shadow_count] = val;
          shadow_max[shadow_count]   = run_max;
          shadow_count++;
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_count--;
          r.data = shadow_value[shadow_count];
        end
      end
      CMD_READ: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = shadow_max[shadow_count - 1];
        end
      end
      default: begin
      end
    endcase
    r.fill = FILL_W'(shadow_count);
    return r;
  endfunction

  // Values to push: a mix of the extremes, small numbers, values right around
  // the current maximum (so that ties and near misses occur), and full-range
  // random values that toggle every bit.
  function automatic logic [VALUE_W-1:0] push_value();
    logic [VALUE_W-1:0] top_max;
    top_max = (shadow_count > 0) ? shadow_max[shadow_count - 1] : '0;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return VALUE_MAX;
      2, 3:    return VALUE_W'($urandom_range(0, 255));
      4, 5:    return top_max + VALUE_W'($urandom_range(0, 4)) - VALUE_W'(2);
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  function automatic void report_error(input string msg);
    error_count++;
    if (error_count <= REPORT_MAX) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  // Presents one item after a random gap and holds it until the block takes
  // it. Once taken, the expected result is queued: the typed-in one when the
  // row carries it, the shadow stack's prediction otherwise. The shadow stack
  // steps in both cases so that it stays in line with the block.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                       input logic known, input stack_result_t known_res);
    int unsigned   gap;
    stack_result_t predicted;
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(8, 60);
      back_to_back = ($urandom_range(0, 3) == 0);
    end
    stretch_left--;
    gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    command <= cmd;
    value   <= val;
    do begin
      @(posedge clk);
    end while (busy);
    predicted = stack_apply(cmd, val);
    pending_results.push_back(known ? known_res : predicted);
  endtask

  // Draws one command with the given weights. Pops and reads carry a random
  // value, which the block has to ignore.
  task automatic random_item(input int unsigned push_w, pop_w, read_w, unused_w);
    int unsigned        pick;
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] val;
    pick = $urandom_range(0, push_w + pop_w + read_w + unused_w - 1);
    if (pick < push_w) begin
      cmd = CMD_PUSH;
    end else if (pick < push_w + pop_w) begin
      cmd = CMD_POP;
    end else if (pick < push_w + pop_w + read_w) begin
      cmd = CMD_READ;
    end else begin
      cmd = CMD_UNUSED;
    end
    val = (cmd == CMD_PUSH) ? push_value() : VALUE_W'($urandom());
    issue(cmd, val, 1'b0, '0);
    if (cmd != CMD_UNUSED) begin
      random_count++;
    end
  endtask

  // Result checker. The block cannot be held off, so every done strobe is
  // taken as a result and matched against the oldest prediction.
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result with no item outstanding: data %h status %0d fill %0d",
                               data, status, fill_level));
      end else begin
        want = pending_results.pop_front();
        if (data !== want.data || status !== want.status || fill_level !== want.fill) begin
          report_error($sformatf("data %h/%h status %0d/%0d fill %0d/%0d (expected/actual)",
                                 want.data, data, want.status, status,
                                 want.fill, fill_level));
        end
      end
    end
  end

  // Watchdog: a stuck handshake or missing results end the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_max_tracking_stack: done, errors");
      $finish;
    end
  end

  initial begin
    random_count = 0;
    shadow_count = 0;
    stretch_left = 0;
    back_to_back = 1'b0;
    rst     <= 1'b1;
    start   <= 1'b0;
    command <= CMD_PUSH;
    value   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].cmd, directed_rows[i].val,
            directed_rows[i].known, directed_rows[i].res);
    end

    // Shallow walk: the stack keeps returning to empty, so empty pops and
    // reads are mixed with short runs of pushes.
    repeat (200) random_item(45, 35, 17, 3);

    // Climb to full with reads along the way, then push into the full stack
    // with a few values, and stay near the top so that rejected pushes and
    // refills alternate.
    while (shadow_count < DEPTH) random_item(92, 2, 5, 1);
    repeat (6) issue(CMD_PUSH, push_value(), 1'b0, '0);
    repeat (40) random_item(55, 12, 30, 3);

    // Descend: pops dominate, so the running maximum is seen falling back as
    // the large values come off the top.
    while (random_count < RANDOM_ITEMS) random_item(30, 55, 13, 2);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_max_tracking_stack: done, clean");
    end else begin
      $display("tb_max_tracking_stack: done, errors");
    end
    $finish;
  end

endmodule
